// ----- rtl/core/snl_pkg.sv -----
// ----------------------------------------------------------------------------
// snl_pkg
// Shared types, character constants and lookup functions for the SQL
// literal normaliser core.
// ----------------------------------------------------------------------------
package snl_pkg;

   // request and response payloads
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } snl_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       out_last;
      logic       out_overflow;
   } snl_rsp_type;

   // response kinds
   localparam logic [1:0] KIND_TEXT     = 2'd0;
   localparam logic [1:0] KIND_ID_START = 2'd1;
   localparam logic [1:0] KIND_ID_BYTE  = 2'd2;
   localparam logic [1:0] KIND_END      = 2'd3;

   // characters
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LC_C   = 8'h63;
   localparam logic [7:0] CH_LC_I   = 8'h69;
   localparam logic [7:0] CH_LC_L   = 8'h6C;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_V   = 8'h76;

   localparam logic [3:0] ID_WORD_LEN = 4'd9;

   typedef enum logic [3:0] {
      M_NORMAL, M_NUMSKIP, M_LISTSKIP, M_EDGE, M_KW, M_NEG, M_SLASH,
      M_CMT, M_STAR, M_SP, M_COLON, M_QUOTE, M_VALUE
   } scan_mode_type;

   typedef enum logic [1:0] {KW_IN, KW_VALUES, KW_LIKE} kw_kind_type;

   typedef enum logic [2:0] {
      ACT_CONSUME, ACT_RETRY, ACT_APPEND, ACT_FAIL, ACT_KWOK, ACT_END
   } act_type;

   typedef enum logic [2:0] {
      ST_RUN, ST_EXEC, ST_FAIL_RD, ST_FAIL_PUT, ST_KW_RD, ST_KW_PUT, ST_KW_QMARK
   } ctrl_state_type;

   typedef enum logic [1:0] {ADDR_NEXT, ADDR_HEAD, ADDR_KW} addr_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         exec;
      addr_sel_type addr_sel;
      logic         fail_put;
      logic         kw_put;
      logic         kw_qmark;
   } snl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic    has_tok;
      logic    end_pend;
      act_type act;
      logic    act_put;
      logic    out_free;
      logic    kw_last;
   } snl_status_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
   endfunction

   // CR and LF go out as spaces
   function automatic logic [7:0] lit_byte(input logic [7:0] b);
      return ((b == CH_CR) || (b == CH_LF)) ? CH_SPACE : b;
   endfunction

   function automatic logic [2:0] kw_len(input kw_kind_type k);
      logic [2:0] r;
      case (k)
         KW_IN:     r = 3'd2;
         KW_VALUES: r = 3'd6;
         KW_LIKE:   r = 3'd4;
         default:   r = 3'd2;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input kw_kind_type k, input logic [2:0] i);
      logic [47:0] w;
      case (k)
         KW_IN:     w = {8'h00, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h69};
         KW_VALUES: w = {8'h73, 8'h65, 8'h75, 8'h6C, 8'h61, 8'h76};
         KW_LIKE:   w = {8'h00, 8'h00, 8'h65, 8'h6B, 8'h69, 8'h6C};
         default:   w = '0;
      endcase
      case (i)
         3'd0:    return w[7:0];
         3'd1:    return w[15:8];
         3'd2:    return w[23:16];
         3'd3:    return w[31:24];
         3'd4:    return w[39:32];
         3'd5:    return w[47:40];
         default: return 8'h00;
      endcase
   endfunction

   // letters of client_id
   function automatic logic [7:0] id_char(input logic [3:0] i);
      logic [7:0] r;
      case (i)
         4'd0:    r = 8'h63;
         4'd1:    r = 8'h6C;
         4'd2:    r = 8'h69;
         4'd3:    r = 8'h65;
         4'd4:    r = 8'h6E;
         4'd5:    r = 8'h74;
         4'd6:    r = 8'h5F;
         4'd7:    r = 8'h69;
         4'd8:    r = 8'h64;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/snl_ctrl.sv -----
// ----------------------------------------------------------------------------
// snl_ctrl
// Sequencer: fetches bytes from the pending buffer, applies the decoded
// action and steps through the multi-response replay and keyword sequences.
// ----------------------------------------------------------------------------
module snl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  snl_pkg::snl_status_type status,
   output snl_pkg::snl_cmd_type    cmd,
   output logic                    req_ready
);

   snl_pkg::ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= snl_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = snl_pkg::ADDR_NEXT;
      req_ready    = 1'b0;
      case (state_ff)
         snl_pkg::ST_RUN: begin
            if (status.has_tok || status.end_pend) begin
               state_in = snl_pkg::ST_EXEC;
            end else begin
               req_ready = 1'b1;
            end
         end
         snl_pkg::ST_EXEC: begin
            if (!status.act_put || status.out_free) begin
               cmd.exec = 1'b1;
               case (status.act)
                  snl_pkg::ACT_RETRY: state_in = snl_pkg::ST_EXEC;
                  snl_pkg::ACT_FAIL:  state_in = snl_pkg::ST_FAIL_RD;
                  snl_pkg::ACT_KWOK:  state_in = snl_pkg::ST_KW_RD;
                  default:            state_in = snl_pkg::ST_RUN;
               endcase
            end
         end
         snl_pkg::ST_FAIL_RD: begin
            cmd.addr_sel = snl_pkg::ADDR_HEAD;
            state_in     = snl_pkg::ST_FAIL_PUT;
         end
         snl_pkg::ST_FAIL_PUT: begin
            cmd.addr_sel = snl_pkg::ADDR_HEAD;
            if (status.out_free) begin
               cmd.fail_put = 1'b1;
               state_in     = snl_pkg::ST_RUN;
            end
         end
         snl_pkg::ST_KW_RD: begin
            cmd.addr_sel = snl_pkg::ADDR_KW;
            state_in     = snl_pkg::ST_KW_PUT;
         end
         snl_pkg::ST_KW_PUT: begin
            cmd.addr_sel = snl_pkg::ADDR_KW;
            if (status.out_free) begin
               cmd.kw_put = 1'b1;
               state_in   = status.kw_last ? snl_pkg::ST_KW_QMARK : snl_pkg::ST_KW_RD;
            end
         end
         snl_pkg::ST_KW_QMARK: begin
            if (status.out_free) begin
               cmd.kw_qmark = 1'b1;
               state_in     = snl_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = snl_pkg::ST_RUN;
         end
      endcase
   end

endmodule

// ----- rtl/core/snl_dp.sv -----
// ----------------------------------------------------------------------------
// snl_dp
// Datapath: pending byte buffer, scan state, byte decoder and the
// response register.
// ----------------------------------------------------------------------------
module snl_dp #(
   parameter int PENDING_DEPTH = 32,
   parameter int ID_MAX        = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  snl_pkg::snl_req_type    req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output snl_pkg::snl_rsp_type    rsp_data,
   input  snl_pkg::snl_cmd_type    cmd,
   output snl_pkg::snl_status_type status
);

   localparam int PTR_W = $clog2(PENDING_DEPTH + 1);
   localparam int MEM_D = 1 << PTR_W;

   // held bytes: run from head, still to be decided up to tail
   logic [7:0]           mem [MEM_D];
   logic [7:0]           rd_data_ff;
   logic [PTR_W-1:0]     rd_addr;

   logic [PTR_W-1:0]     head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic [PTR_W-1:0]     kwk_ff, kwk_in;
   logic                 end_ff, end_in;
   logic [7:0]           prev_ff, prev_in, pprev_ff, pprev_in;
   logic [7:0]           run_last_ff, run_last_in, run_prev_ff, run_prev_in;
   snl_pkg::scan_mode_type mode_ff, mode_in;
   snl_pkg::kw_kind_type kind_ff, kind_in;
   logic [7:0]           close_ff, close_in;
   logic [3:0]           idx_ff, idx_in;
   logic [7:0]           idlen_ff, idlen_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   snl_pkg::snl_rsp_type rsp_data_ff, rsp_data_in;

   // decoder outputs
   snl_pkg::act_type       act;
   snl_pkg::scan_mode_type m_nx;
   snl_pkg::kw_kind_type   k_nx;
   logic                   p_en, flush, ovf_set, has_tok, out_free, wr_en;
   logic [7:0]             p_byte, t, lc, idlen_nx, opener;
   logic [1:0]             p_kind;
   logic [3:0]             idx_nx;
   logic [7:0]             scan_r;

   // comment scan for client_id: returns {mode, progress}
   function automatic logic [7:0] cmt_scan(input logic [7:0] b, input logic [3:0] k);
      logic [7:0] lb;
      lb = snl_pkg::to_lower(b);
      if (b == snl_pkg::CH_STAR) begin
         return {snl_pkg::M_STAR, 4'd0};
      end else if ((k < snl_pkg::ID_WORD_LEN) && (lb == snl_pkg::id_char(k))) begin
         if (k == snl_pkg::ID_WORD_LEN - 4'd1) begin
            return {snl_pkg::M_SP, 4'd0};
         end else begin
            return {snl_pkg::M_CMT, 4'(k + 4'd1)};
         end
      end else begin
         return {snl_pkg::M_CMT, (lb == snl_pkg::CH_LC_C) ? 4'd1 : 4'd0};
      end
   endfunction

   assign has_tok  = (PTR_W'(head_ff + cnt_ff)) != tail_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign t        = rd_data_ff;
   assign lc       = snl_pkg::to_lower(t);
   assign opener   = (kind_ff == snl_pkg::KW_LIKE) ? snl_pkg::CH_QUOTE : snl_pkg::CH_LPAR;
   assign wr_en    = req_valid && req_ready && (req_data.in_byte != snl_pkg::CH_NUL);

   // buffer read address
   always_comb begin
      case (cmd.addr_sel)
         snl_pkg::ADDR_HEAD: rd_addr = head_ff;
         snl_pkg::ADDR_KW:   rd_addr = PTR_W'(head_ff + kwk_ff);
         default:            rd_addr = PTR_W'(head_ff + cnt_ff);
      endcase
   end

   // buffer memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= req_data.in_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // decode the byte at the decision point
   always_comb begin
      act      = snl_pkg::ACT_CONSUME;
      m_nx     = mode_ff;
      k_nx     = kind_ff;
      p_en     = 1'b0;
      p_byte   = 8'h00;
      p_kind   = snl_pkg::KIND_TEXT;
      flush    = 1'b0;
      ovf_set  = 1'b0;
      idx_nx   = idx_ff;
      idlen_nx = idlen_ff;
      scan_r   = cmt_scan(t, idx_ff);
      case (mode_ff)
         snl_pkg::M_NORMAL: begin
            if (!has_tok) begin
               act    = snl_pkg::ACT_END;
               p_en   = 1'b1;
               p_kind = snl_pkg::KIND_END;
            end else if (snl_pkg::is_digit(t) &&
                         ((prev_ff == snl_pkg::CH_EQ) || (prev_ff == snl_pkg::CH_GT) ||
                          (prev_ff == snl_pkg::CH_LT) || snl_pkg::is_space(prev_ff) ||
                          (prev_ff == snl_pkg::CH_COMMA) || (prev_ff == snl_pkg::CH_LPAR))) begin
               p_en   = 1'b1;
               p_byte = snl_pkg::CH_QMARK;
               m_nx   = snl_pkg::M_NUMSKIP;
            end else if (snl_pkg::is_digit(t) &&
                         ((prev_ff == snl_pkg::CH_UNDER) ||
                          ((prev_ff == snl_pkg::CH_LC_N) && (pprev_ff == snl_pkg::CH_UNDER)))) begin
               act  = snl_pkg::ACT_APPEND;
               m_nx = snl_pkg::M_EDGE;
            end else if ((lc == snl_pkg::CH_LC_I) || (lc == snl_pkg::CH_LC_V) ||
                         (lc == snl_pkg::CH_LC_L)) begin
               act  = snl_pkg::ACT_APPEND;
               m_nx = snl_pkg::M_KW;
               k_nx = (lc == snl_pkg::CH_LC_I) ? snl_pkg::KW_IN :
                      (lc == snl_pkg::CH_LC_V) ? snl_pkg::KW_VALUES : snl_pkg::KW_LIKE;
            end else if ((t == snl_pkg::CH_DASH) && snl_pkg::is_space(prev_ff)) begin
               act  = snl_pkg::ACT_APPEND;
               m_nx = snl_pkg::M_NEG;
            end else if (t == snl_pkg::CH_SLASH) begin
               act  = snl_pkg::ACT_APPEND;
               m_nx = snl_pkg::M_SLASH;
            end else begin
               p_en   = 1'b1;
               p_byte = snl_pkg::lit_byte(t);
            end
         end
         snl_pkg::M_NUMSKIP: begin
            if (!(has_tok && snl_pkg::is_digit(t))) begin
               act  = snl_pkg::ACT_RETRY;
               m_nx = snl_pkg::M_NORMAL;
            end
         end
         snl_pkg::M_LISTSKIP: begin
            if (!has_tok || (t == close_ff)) begin
               act  = snl_pkg::ACT_RETRY;
               m_nx = snl_pkg::M_NORMAL;
            end
         end
         snl_pkg::M_EDGE: begin
            if (!has_tok) begin
               act = snl_pkg::ACT_FAIL;
            end else if (snl_pkg::is_digit(t)) begin
               act = snl_pkg::ACT_APPEND;
            end else if (t == snl_pkg::CH_UNDER) begin
               act    = snl_pkg::ACT_RETRY;
               flush  = 1'b1;
               p_en   = 1'b1;
               p_byte = snl_pkg::CH_QMARK;
               m_nx   = snl_pkg::M_NORMAL;
            end else begin
               act = snl_pkg::ACT_FAIL;
            end
         end
         snl_pkg::M_KW: begin
            if (!has_tok) begin
               act = snl_pkg::ACT_FAIL;
            end else if (cnt_ff < PTR_W'(snl_pkg::kw_len(kind_ff))) begin
               act = (lc == snl_pkg::kw_char(kind_ff, cnt_ff[2:0])) ?
                     snl_pkg::ACT_APPEND : snl_pkg::ACT_FAIL;
            end else if (snl_pkg::is_space(t)) begin
               act = snl_pkg::ACT_APPEND;
            end else if (t == opener) begin
               act = snl_pkg::ACT_KWOK;
            end else begin
               act = snl_pkg::ACT_FAIL;
            end
         end
         snl_pkg::M_NEG: begin
            if (has_tok && snl_pkg::is_digit(t)) begin
               flush  = 1'b1;
               p_en   = 1'b1;
               p_byte = snl_pkg::CH_QMARK;
               m_nx   = snl_pkg::M_NUMSKIP;
            end else begin
               act = snl_pkg::ACT_FAIL;
            end
         end
         snl_pkg::M_SLASH: begin
            if (has_tok && (t == snl_pkg::CH_STAR)) begin
               flush  = 1'b1;
               m_nx   = snl_pkg::M_CMT;
               idx_nx = 4'd0;
            end else begin
               act = snl_pkg::ACT_FAIL;
            end
         end
         snl_pkg::M_CMT, snl_pkg::M_STAR, snl_pkg::M_SP, snl_pkg::M_COLON,
         snl_pkg::M_QUOTE, snl_pkg::M_VALUE: begin
            if (!has_tok) begin
               act    = snl_pkg::ACT_END;
               p_en   = 1'b1;
               p_kind = snl_pkg::KIND_END;
            end else begin
               case (mode_ff)
                  snl_pkg::M_CMT: begin
                     m_nx   = snl_pkg::scan_mode_type'(scan_r[7:4]);
                     idx_nx = scan_r[3:0];
                  end
                  snl_pkg::M_STAR: begin
                     if (t == snl_pkg::CH_SLASH) begin
                        m_nx   = snl_pkg::M_NORMAL;
                        idx_nx = 4'd0;
                     end else begin
                        m_nx   = snl_pkg::scan_mode_type'(scan_r[7:4]);
                        idx_nx = scan_r[3:0];
                     end
                  end
                  snl_pkg::M_SP: begin
                     if (t == snl_pkg::CH_DQUOTE) begin
                        m_nx = snl_pkg::M_COLON;
                     end else if (!snl_pkg::is_space(t)) begin
                        m_nx   = snl_pkg::scan_mode_type'(scan_r[7:4]);
                        idx_nx = scan_r[3:0];
                     end
                  end
                  snl_pkg::M_COLON: begin
                     if (t == snl_pkg::CH_COLON) begin
                        m_nx = snl_pkg::M_QUOTE;
                     end
                  end
                  snl_pkg::M_QUOTE: begin
                     if (t == snl_pkg::CH_DQUOTE) begin
                        m_nx     = snl_pkg::M_VALUE;
                        p_en     = 1'b1;
                        p_kind   = snl_pkg::KIND_ID_START;
                        idlen_nx = 8'd0;
                     end
                  end
                  default: begin
                     // client id value
                     if (t == snl_pkg::CH_DQUOTE) begin
                        m_nx   = snl_pkg::M_CMT;
                        idx_nx = 4'd0;
                     end else if (idlen_ff < 8'(ID_MAX)) begin
                        p_en     = 1'b1;
                        p_byte   = t;
                        p_kind   = snl_pkg::KIND_ID_BYTE;
                        idlen_nx = idlen_ff + 8'd1;
                     end
                  end
               endcase
            end
         end
         default: begin
            act  = snl_pkg::ACT_RETRY;
            m_nx = snl_pkg::M_NORMAL;
         end
      endcase
      // a run that outgrows the buffer is abandoned
      if ((act == snl_pkg::ACT_APPEND) && (cnt_ff >= PTR_W'(PENDING_DEPTH - 1))) begin
         act     = snl_pkg::ACT_FAIL;
         ovf_set = 1'b1;
      end
   end

   // next state of the datapath registers
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      kwk_in       = kwk_ff;
      end_in       = end_ff;
      prev_in      = prev_ff;
      pprev_in     = pprev_ff;
      run_last_in  = run_last_ff;
      run_prev_in  = run_prev_ff;
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      close_in     = close_ff;
      idx_in       = idx_ff;
      idlen_in     = idlen_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // new request
      if (req_valid && req_ready) begin
         if (wr_en) begin
            tail_in = tail_ff + PTR_W'(1);
         end
         end_in = end_ff || req_data.in_last || (req_data.in_byte == snl_pkg::CH_NUL);
      end

      if (cmd.exec) begin
         if (p_en) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_byte     = p_byte;
            rsp_data_in.out_kind     = p_kind;
            rsp_data_in.out_last     = (act == snl_pkg::ACT_END);
            rsp_data_in.out_overflow = 1'b0;
         end
         case (act)
            snl_pkg::ACT_CONSUME: begin
               head_in  = head_ff + cnt_ff + PTR_W'(1);
               cnt_in   = '0;
               pprev_in = flush ? run_last_ff : prev_ff;
               prev_in  = t;
               mode_in  = m_nx;
               idx_in   = idx_nx;
               idlen_in = idlen_nx;
            end
            snl_pkg::ACT_RETRY: begin
               head_in = head_ff + cnt_ff;
               cnt_in  = '0;
               mode_in = m_nx;
               if (flush) begin
                  prev_in  = run_last_ff;
                  pprev_in = run_prev_ff;
               end
            end
            snl_pkg::ACT_APPEND: begin
               cnt_in      = cnt_ff + PTR_W'(1);
               run_prev_in = (cnt_ff == '0) ? prev_ff : run_last_ff;
               run_last_in = t;
               mode_in     = m_nx;
               kind_in     = k_nx;
            end
            snl_pkg::ACT_FAIL: begin
               ovf_in = ovf_set;
            end
            snl_pkg::ACT_KWOK: begin
               kwk_in   = '0;
               close_in = (kind_ff == snl_pkg::KW_LIKE) ? snl_pkg::CH_QUOTE : snl_pkg::CH_RPAR;
            end
            default: begin
               // end of query: back to reset values
               head_in  = '0;
               tail_in  = '0;
               cnt_in   = '0;
               end_in   = 1'b0;
               prev_in  = 8'h00;
               pprev_in = 8'h00;
               mode_in  = snl_pkg::M_NORMAL;
               close_in = 8'h00;
               idx_in   = 4'd0;
               idlen_in = 8'd0;
            end
         endcase
      end

      // failed run: first byte goes out as text, rest is decided again
      if (cmd.fail_put) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_byte     = snl_pkg::lit_byte(rd_data_ff);
         rsp_data_in.out_kind     = snl_pkg::KIND_TEXT;
         rsp_data_in.out_last     = 1'b0;
         rsp_data_in.out_overflow = ovf_ff;
         ovf_in                   = 1'b0;
         head_in                  = head_ff + PTR_W'(1);
         cnt_in                   = '0;
         mode_in                  = snl_pkg::M_NORMAL;
         pprev_in                 = prev_ff;
         prev_in                  = rd_data_ff;
      end

      // matched keyword: run and opener go out unchanged
      if (cmd.kw_put) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_byte     = rd_data_ff;
         rsp_data_in.out_kind     = snl_pkg::KIND_TEXT;
         rsp_data_in.out_last     = 1'b0;
         rsp_data_in.out_overflow = 1'b0;
         pprev_in                 = prev_ff;
         prev_in                  = rd_data_ff;
         kwk_in                   = kwk_ff + PTR_W'(1);
      end

      if (cmd.kw_qmark) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_byte     = snl_pkg::CH_QMARK;
         rsp_data_in.out_kind     = snl_pkg::KIND_TEXT;
         rsp_data_in.out_last     = 1'b0;
         rsp_data_in.out_overflow = 1'b0;
         head_in                  = head_ff + cnt_ff + PTR_W'(1);
         cnt_in                   = '0;
         mode_in                  = snl_pkg::M_LISTSKIP;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         kwk_ff       <= '0;
         end_ff       <= 1'b0;
         prev_ff      <= 8'h00;
         pprev_ff     <= 8'h00;
         mode_ff      <= snl_pkg::M_NORMAL;
         kind_ff      <= snl_pkg::KW_IN;
         close_ff     <= 8'h00;
         idx_ff       <= 4'd0;
         idlen_ff     <= 8'd0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         kwk_ff       <= kwk_in;
         end_ff       <= end_in;
         prev_ff      <= prev_in;
         pprev_ff     <= pprev_in;
         mode_ff      <= mode_in;
         kind_ff      <= kind_in;
         close_ff     <= close_in;
         idx_ff       <= idx_in;
         idlen_ff     <= idlen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_last_ff <= run_last_in;
      run_prev_ff <= run_prev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status          = '0;
      status.has_tok  = has_tok;
      status.end_pend = end_ff;
      status.act      = act;
      status.act_put  = p_en;
      status.out_free = out_free;
      status.kw_last  = (kwk_ff == cnt_ff);
   end

endmodule

// ----- rtl/core/sql_literal_normalizer_core.sv -----
// ----------------------------------------------------------------------------
// sql_literal_normalizer_core
// Replaces literals in query text with '?', drops comments and reports any
// client id found inside them.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one raw query byte per request (in_byte, in_last). A NUL
//          byte or in_last ends the query; an end-of-query response follows.
//   rsp_*  carries normalised text bytes, client id markers and bytes, and
//          the end-of-query marker, through one output register.
// Timing: a byte that is decided at once passes buffer read, decode and
//   update before the next ready. Bytes held in an undecided run are
//   re-read from the pending buffer on a failed match, after the first byte
//   is emitted; a matched keyword replays each held byte, the opener and a
//   '?'. The pending buffer has one read port, so held bytes are read one at
//   a time. Results: 0 to PENDING_DEPTH+2 per request.
// Reset: synchronous, returns to plain text mode with an empty buffer and
//   no previous byte.
// Back-pressure: when rsp_ready is low the response register holds and the
//   sequencer waits; req_ready stays low until every received byte is decoded.
// ----------------------------------------------------------------------------
module sql_literal_normalizer_core #(
   parameter int PENDING_DEPTH = 32,
   parameter int ID_MAX        = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  snl_pkg::snl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output snl_pkg::snl_rsp_type rsp_data
);

   snl_pkg::snl_cmd_type    cmd;
   snl_pkg::snl_status_type status;

   snl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   snl_dp #(
      .PENDING_DEPTH (PENDING_DEPTH),
      .ID_MAX        (ID_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- rtl/core/snl_checker.sv -----
// ----------------------------------------------------------------------------
// snl_checker
// Port-level checks for the SQL literal normaliser core.
// ----------------------------------------------------------------------------
module snl_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input snl_pkg::snl_rsp_type rsp_data
);

   // nothing comes out the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // last flag marks end of query and nothing else
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_last == (rsp_data.out_kind == snl_pkg::KIND_END)))
      else $error("last flag does not match end kind");

   // overflow only flags a text byte
   a_ovf_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_overflow) |-> (rsp_data.out_kind == snl_pkg::KIND_TEXT))
      else $error("overflow on non-text response");

   // a stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response changed while stalled");

endmodule

bind sql_literal_normalizer_core snl_checker u_snl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
